### sv/olst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered list engine.
// No dependencies; every other file in this block uses it.
package olst_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int MATCH_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_END    = 3'd0,
        REQ_ADD_FRONT  = 3'd1,
        REQ_INSERT_AT  = 3'd2,
        REQ_REM_END    = 3'd3,
        REQ_REM_FRONT  = 3'd4,
        REQ_REM_AT     = 3'd5,
        REQ_SEARCH     = 3'd6
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Broadcast to every cell in the chain for one accepted request.
    typedef struct packed {
        logic ins;
        logic rem;
        logic srch;
    } cell_op_t;

endpackage

### sv/olst_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry and its search hit.
// Depends on olst_pkg for the broadcast operation struct.
module olst_cell #(
    parameter int VALUE_BITS = olst_pkg::VALUE_BITS_DEF,
    parameter int CAPACITY   = olst_pkg::CAPACITY_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                                clk,
    input  olst_pkg::cell_op_t                  op,
    input  logic [$clog2(CAPACITY)-1:0]         at_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]       held_count,
    input  logic [VALUE_BITS-1:0]               new_val,
    input  logic [VALUE_BITS-1:0]               left_val,
    input  logic [VALUE_BITS-1:0]               right_val,
    output logic [VALUE_BITS-1:0]               val,
    output logic                                hit
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic                  hit_reg;
    logic                  hit_next;

    always_comb
    begin
        val_next = val_reg;
        hit_next = hit_reg;
        if (op.ins)
        begin
            // open the gap: cells past the insert point take from the left
            if (MY_IDX > at_idx)
                val_next = left_val;
            else if (MY_IDX == at_idx)
                val_next = new_val;
        end
        else if (op.rem)
        begin
            // close the gap: cells from the removed point take from the right
            if (MY_IDX >= at_idx)
                val_next = right_val;
        end
        if (op.srch)
            hit_next = (MY_CNT < held_count) && (val_reg == new_val);
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        hit_reg <= hit_next;
    end

    assign val = val_reg;
    assign hit = hit_reg;

endmodule

### sv/olst_ctrl.sv
`timescale 1ns / 1ps
// Request decoder and entry counter for the ordered list engine.
// Depends on olst_pkg for request codes, status codes and the cell op struct.
module olst_ctrl #(
    parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_fire,
    input  logic [olst_pkg::REQ_W-1:0]          req_type,
    input  logic [olst_pkg::POS_W-1:0]          list_position,
    output olst_pkg::cell_op_t                  cell_op,
    output logic [$clog2(CAPACITY)-1:0]         at_idx,
    output logic [$clog2(CAPACITY+1)-1:0]       held_count,
    output logic [$clog2(CAPACITY+1)-1:0]       count_after,
    output olst_pkg::status_t                   pre_status,
    output logic                                is_search
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int CMP_W = ((CNT_W > olst_pkg::POS_W) ? CNT_W : olst_pkg::POS_W) + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] k_wide;
    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_rem;
    logic             do_srch;
    olst_pkg::status_t status;

    always_comb
    begin
        cnt_ext = CMP_W'(count_reg);
        pos_ext = CMP_W'(list_position);
        full    = (count_reg == CNT_W'(CAPACITY));
        empty   = (count_reg == '0);
        status  = olst_pkg::ST_OK;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_srch = 1'b0;
        k_wide  = '0;
        unique case (olst_pkg::req_t'(req_type))
            olst_pkg::REQ_ADD_END:
            begin
                if (full)
                    status = olst_pkg::ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    k_wide = cnt_ext;
                end
            end
            olst_pkg::REQ_ADD_FRONT:
            begin
                if (full)
                    status = olst_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            olst_pkg::REQ_INSERT_AT:
            begin
                // position check wins over the full check
                if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                    status = olst_pkg::ST_BAD_POS;
                else if (full)
                    status = olst_pkg::ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    k_wide = pos_ext - CMP_W'(1);
                end
            end
            olst_pkg::REQ_REM_END:
            begin
                if (empty)
                    status = olst_pkg::ST_EMPTY;
                else
                begin
                    do_rem = 1'b1;
                    k_wide = cnt_ext - CMP_W'(1);
                end
            end
            olst_pkg::REQ_REM_FRONT:
            begin
                if (empty)
                    status = olst_pkg::ST_EMPTY;
                else
                    do_rem = 1'b1;
            end
            olst_pkg::REQ_REM_AT:
            begin
                if (empty)
                    status = olst_pkg::ST_EMPTY;
                else if (pos_ext == '0 || pos_ext > cnt_ext)
                    status = olst_pkg::ST_BAD_POS;
                else
                begin
                    do_rem = 1'b1;
                    k_wide = pos_ext - CMP_W'(1);
                end
            end
            olst_pkg::REQ_SEARCH:
            begin
                do_srch = 1'b1;
            end
            default:
            begin
            end
        endcase

        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_rem)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (req_fire)
            count_reg <= count_next;
    end

    assign cell_op.ins  = req_fire & do_ins;
    assign cell_op.rem  = req_fire & do_rem;
    assign cell_op.srch = req_fire & do_srch;
    assign at_idx       = k_wide[IDX_W-1:0];
    assign held_count   = count_reg;
    assign count_after  = count_next;
    assign pre_status   = status;
    assign is_search    = do_srch;

endmodule

### sv/ordered_list_engine.sv
`timescale 1ns / 1ps
// Top level of the ordered list engine: cell chain, decoder, result stages.
// Depends on olst_pkg, olst_ctrl and olst_cell.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   request | req_valid / req_ready  | req_type, item_value, list_position
//   result  | rsp_valid / rsp_ready  | status_code, match_index, entry_count
//
// One request per cycle while the result register is not stalled.
// Shifts and compares happen in all cells in parallel on the accept edge; when the
// middle stage moves on, the first search hit is encoded and loaded into the result register.
// A stalled result register holds one request in the middle stage, then
// req_ready drops. Reset empties the list and both result stages.
module ordered_list_engine #(
    parameter int CAPACITY   = olst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = olst_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [olst_pkg::REQ_W-1:0]          req_type,
    input  logic signed [olst_pkg::VAL_W-1:0]   item_value,
    input  logic [olst_pkg::POS_W-1:0]          list_position,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [olst_pkg::STATUS_W-1:0]       status_code,
    output logic [olst_pkg::MATCH_W-1:0]        match_index,
    output logic [olst_pkg::COUNT_W-1:0]        entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);

    logic                         req_fire;
    logic                         move;
    olst_pkg::cell_op_t           cell_op;
    logic [IDX_W-1:0]             at_idx;
    logic [CNT_W-1:0]             held_count;
    logic [CNT_W-1:0]             count_after;
    olst_pkg::status_t            pre_status;
    logic                         is_search;

    logic [VALUE_BITS+olst_pkg::VAL_W-1:0] val_ext;
    logic [VALUE_BITS-1:0]        new_val;
    logic [VALUE_BITS-1:0]        cell_val [CAPACITY];
    logic [CAPACITY-1:0]          hits;
    logic [CAPACITY-1:0]          first_hit;
    logic [IDX_W-1:0]             hit_idx;
    logic                         found;

    logic                         pend_valid_reg;
    olst_pkg::status_t            pend_status_reg;
    logic                         pend_search_reg;
    logic [CNT_W-1:0]             pend_count_reg;

    logic                         out_valid_reg;
    olst_pkg::status_t            out_status_reg;
    olst_pkg::status_t            out_status_next;
    logic [IDX_W-1:0]             out_idx_reg;
    logic [IDX_W-1:0]             out_idx_next;
    logic [CNT_W-1:0]             out_count_reg;
    logic [IDX_W+olst_pkg::MATCH_W-1:0] idx_ext;
    logic [CNT_W+olst_pkg::COUNT_W-1:0] cnt_ext;

    assign move      = pend_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !pend_valid_reg || move;
    assign req_fire  = req_valid && req_ready;

    // keep the low value bits, zero-fill when cells are wider than the port
    assign val_ext = {{VALUE_BITS{1'b0}}, item_value};
    assign new_val = val_ext[VALUE_BITS-1:0];

    olst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_fire      (req_fire),
        .req_type      (req_type),
        .list_position (list_position),
        .cell_op       (cell_op),
        .at_idx        (at_idx),
        .held_count    (held_count),
        .count_after   (count_after),
        .pre_status    (pre_status),
        .is_search     (is_search)
    );

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_BITS-1:0] left_val;
            logic [VALUE_BITS-1:0] right_val;
            if (gi == 0)
            begin : g_first
                assign left_val = new_val;
            end
            else
            begin : g_mid_l
                assign left_val = cell_val[gi-1];
            end
            if (gi == CAPACITY-1)
            begin : g_last
                assign right_val = cell_val[gi];
            end
            else
            begin : g_mid_r
                assign right_val = cell_val[gi+1];
            end

            olst_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CAPACITY   (CAPACITY),
                .CELL_IDX   (gi)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op),
                .at_idx     (at_idx),
                .held_count (held_count),
                .new_val    (new_val),
                .left_val   (left_val),
                .right_val  (right_val),
                .val        (cell_val[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    // isolate the lowest hit, then encode its position
    assign first_hit = hits & (~hits + CAPACITY'(1));
    assign found     = |hits;

    always_comb
    begin
        logic [IDX_W-1:0] pos;
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos = IDX_W'(i);
            for (int b = 0; b < IDX_W; b++)
                hit_idx[b] = hit_idx[b] | (first_hit[i] & pos[b]);
        end
    end

    always_comb
    begin
        out_status_next = pend_status_reg;
        out_idx_next    = '0;
        if (pend_search_reg)
        begin
            if (found)
            begin
                out_status_next = olst_pkg::ST_OK;
                out_idx_next    = hit_idx;
            end
            else
                out_status_next = olst_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_fire)
                pend_valid_reg <= 1'b1;
            else if (move)
                pend_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pend_status_reg <= pre_status;
            pend_search_reg <= is_search;
            pend_count_reg  <= count_after;
        end
        if (move)
        begin
            out_status_reg <= out_status_next;
            out_idx_reg    <= out_idx_next;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign idx_ext     = {{olst_pkg::MATCH_W{1'b0}}, out_idx_reg};
    assign cnt_ext     = {{olst_pkg::COUNT_W{1'b0}}, out_count_reg};
    assign rsp_valid   = out_valid_reg;
    assign status_code = out_status_reg;
    assign match_index = idx_ext[olst_pkg::MATCH_W-1:0];
    assign entry_count = cnt_ext[olst_pkg::COUNT_W-1:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == olst_pkg::ST_FULL)
            |-> out_count_reg == CNT_W'(CAPACITY))
        else $error("full status without a full list");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == olst_pkg::ST_EMPTY)
            |-> out_count_reg == '0)
        else $error("empty status with entries held");

    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_idx_reg != '0) |-> out_status_reg == olst_pkg::ST_OK)
        else $error("match index on a failed request");

    a_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> pend_valid_reg)
        else $error("accepted request lost before the result stage");
`endif

endmodule
